// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the calculator RTL.
// No dependencies; include it with a bare file name in files that check themselves.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- hw/rtl/rpn_pkg.sv -----
// Shared types, codes and sizes for the RPN stack calculator.
// No dependencies; used by rpn_alu and the top level.
`timescale 1ns / 1ps

package rpn_pkg;

  // Stack geometry.
  localparam int STACK_DEPTH = 4;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // Q16.16 data word.
  typedef logic signed [31:0] word_t;

  // Operator codes.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_DIVZERO   = 2'd2;
  localparam logic [1:0] ST_UNDERFLOW = 2'd3;

  // Saturation bounds.
  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN = 32'sh8000_0000;

  // Request into the arithmetic unit.
  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } alu_req_t;

  // Response from the arithmetic unit.
  typedef struct packed {
    logic done;
  } alu_rsp_t;

endpackage

// ----- hw/rtl/rpn_alu.sv -----
// Iterative Q16.16 arithmetic unit: saturating add/subtract, shift-add multiply,
// restoring divide, all around one shared 34-bit adder. Depends on rpn_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rpn_alu (
  input  logic             clk,
  input  logic             rst_n,
  input  rpn_pkg::alu_req_t req,
  input  rpn_pkg::word_t   opa,
  input  rpn_pkg::word_t   opb,
  output rpn_pkg::alu_rsp_t rsp,
  output rpn_pkg::word_t   result
);

  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_RUN  = 2'd1;
  localparam logic [1:0] A_NEG  = 2'd2;
  localparam logic [1:0] A_SAT  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic               done_r, done_nxt;
  logic [1:0]         op_r;
  logic               neg_r;
  logic [5:0]         cnt_r;
  logic [31:0]        hi_r;
  logic [47:0]        lo_r;
  logic [31:0]        mag_r;
  logic signed [63:0] prod_r;
  rpn_pkg::word_t     result_r;

  logic [33:0]        add_x, add_y, add_sum;
  logic               add_sub;
  logic [31:0]        abs_a, abs_b;
  logic [63:0]        mag64;
  logic signed [63:0] sat_in;
  rpn_pkg::word_t     addsub_sat, wide_sat;
  logic               is_addsub;

  // Magnitudes of the operands; the most negative value maps to 2^31 unsigned.
  assign abs_a = opa[31] ? (~opa + 32'd1) : opa;
  assign abs_b = opb[31] ? (~opb + 32'd1) : opb;
  assign is_addsub = (req.op == rpn_pkg::OP_ADD) || (req.op == rpn_pkg::OP_SUB);

  // Shared adder operand selection.
  always_comb begin
    if (state_r == A_IDLE) begin
      add_x   = {{2{opa[31]}}, opa};
      add_y   = {{2{opb[31]}}, opb};
      add_sub = (req.op == rpn_pkg::OP_SUB);
    end else if (op_r == rpn_pkg::OP_MUL) begin
      add_x   = {2'b00, hi_r};
      add_y   = lo_r[0] ? {2'b00, mag_r} : 34'd0;
      add_sub = 1'b0;
    end else begin
      add_x   = {1'b0, hi_r, lo_r[47]};
      add_y   = {2'b00, mag_r};
      add_sub = 1'b1;
    end
  end

  assign add_sum = add_x + (add_sub ? ~add_y : add_y) + {33'd0, add_sub};

  // Saturation of the add/subtract sum to 32 bits.
  always_comb begin
    if (add_sum[33:31] == {3{add_sum[33]}}) begin
      addsub_sat = add_sum[31:0];
    end else begin
      addsub_sat = add_sum[33] ? rpn_pkg::WORD_MIN : rpn_pkg::WORD_MAX;
    end
  end

  // Product or quotient magnitude, and the final scale and saturation.
  assign mag64  = (op_r == rpn_pkg::OP_MUL) ? {hi_r, lo_r[31:0]} : {16'd0, lo_r};
  assign sat_in = (op_r == rpn_pkg::OP_MUL) ? (prod_r >>> 16) : prod_r;

  always_comb begin
    if (sat_in[63:31] == {33{sat_in[63]}}) begin
      wide_sat = sat_in[31:0];
    end else begin
      wide_sat = sat_in[63] ? rpn_pkg::WORD_MIN : rpn_pkg::WORD_MAX;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    case (state_r)
      A_IDLE: begin
        if (req.start) begin
          if (is_addsub) begin
            done_nxt = 1'b1;
          end else begin
            state_nxt = A_RUN;
          end
        end
      end
      A_RUN: begin
        if (cnt_r == 6'd1) begin
          state_nxt = A_NEG;
        end
      end
      A_NEG: begin
        state_nxt = A_SAT;
      end
      A_SAT: begin
        done_nxt  = 1'b1;
        state_nxt = A_IDLE;
      end
      default: begin
        state_nxt = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      A_IDLE: begin
        if (req.start) begin
          op_r  <= req.op;
          neg_r <= opa[31] ^ opb[31];
          hi_r  <= 32'd0;
          if (is_addsub) begin
            result_r <= addsub_sat;
          end else if (req.op == rpn_pkg::OP_MUL) begin
            lo_r  <= {16'd0, abs_b};
            mag_r <= abs_a;
            cnt_r <= 6'd32;
          end else begin
            lo_r  <= {abs_a, 16'd0};
            mag_r <= abs_b;
            cnt_r <= 6'd48;
          end
        end
      end
      A_RUN: begin
        cnt_r <= cnt_r - 6'd1;
        if (op_r == rpn_pkg::OP_MUL) begin
          // Add the multiplicand when the multiplier bit is set, then shift right.
          hi_r <= add_sum[32:1];
          lo_r <= {16'd0, add_sum[0], lo_r[31:1]};
        end else begin
          // Restoring divide step: keep the difference when it did not borrow.
          hi_r <= add_sum[33] ? add_x[31:0] : add_sum[31:0];
          lo_r <= {lo_r[46:0], ~add_sum[33]};
        end
      end
      A_NEG: begin
        prod_r <= neg_r ? -$signed(mag64) : $signed(mag64);
      end
      A_SAT: begin
        result_r <= wide_sat;
      end
      default: begin
      end
    endcase
  end

  assign rsp.done = done_r;
  assign result   = result_r;

  `ASSERT_IMP(a_alu_start_idle, clk, rst_n, req.start, state_r == A_IDLE)
  `ASSERT_IMP(a_alu_run_count, clk, rst_n, state_r == A_RUN, cnt_r != 6'd0)
  `ASSERT_NXT(a_alu_done_pulse, clk, rst_n, done_r, !done_r)

endmodule

// ----- hw/rtl/rpn_four_level_stack_calculator.sv -----
// Top level of the four-level RPN stack calculator: token decode, operand stack,
// status latch and output register. Depends on rpn_pkg and rpn_alu.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
// One token is taken per input transaction (in_valid/in_ready). Every token
// produces exactly one result transaction on out_valid/out_ready carrying the
// stack top in Q16.16, a status code and the end-of-expression flag.
// The block works on one token at a time; in_ready is high only while idle.
// Pushes, errors and tokens ignored under a latched error go from decode straight
// to the output stage. Add and subtract go through the shared arithmetic unit;
// multiply uses its bit-serial shift-add multiplier (32 steps) and divide its
// restoring divider (48 steps).
// A divide by zero skips the unit.
// in_ready returns in the same cycle that a result is registered.
// The result sits in an output register, so a stalled receiver does not stop
// the next token from being accepted and computed; that token waits at the
// output stage until the held result is taken.
// Reset empties the stack, clears the error latch and drops out_valid.
// The token flagged last clears the stack and the latch when its result is
// moved into the output register.

module rpn_four_level_stack_calculator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic signed [15:0] in_operand_value,
  input  logic [1:0]         in_operation,
  input  logic               in_last_token,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_top_value,
  output logic [1:0]         out_status,
  output logic               out_expression_done
);

  localparam int DEPTH = rpn_pkg::STACK_DEPTH;
  localparam int CW    = rpn_pkg::CNT_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_CALC   = 2'd2;
  localparam logic [1:0] S_OUT    = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CW-1:0]      cnt_r;
  logic [1:0]         err_r;
  logic               out_valid_r;
  rpn_pkg::word_t     stack_r [DEPTH];
  logic               tok_kind_r;
  logic signed [15:0] tok_val_r;
  logic [1:0]         tok_op_r;
  logic               tok_last_r;
  logic               divz_r;
  rpn_pkg::word_t     out_top_r;
  logic [1:0]         out_status_r;
  logic               out_done_r;

  logic               in_fire, no_err, decode_ok, push_en, ovf_set, unf_set;
  logic               divz_hit, alu_start, pop_en, out_load;
  logic               last_load, err_shown;
  rpn_pkg::word_t     pop_val, alu_result;
  rpn_pkg::alu_req_t  alu_req;
  rpn_pkg::alu_rsp_t  alu_rsp;

  // Token decode.
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign no_err    = (err_r == rpn_pkg::ST_OK);
  assign decode_ok = (state_r == S_DECODE) && no_err;
  assign push_en   = decode_ok && !tok_kind_r && (cnt_r < CW'(DEPTH));
  assign ovf_set   = decode_ok && !tok_kind_r && (cnt_r >= CW'(DEPTH));
  assign unf_set   = decode_ok && tok_kind_r && (cnt_r < CW'(2));
  assign divz_hit  = decode_ok && tok_kind_r && (cnt_r >= CW'(2)) &&
                     (tok_op_r == rpn_pkg::OP_DIV) && (stack_r[0] == '0);
  assign alu_start = decode_ok && tok_kind_r && (cnt_r >= CW'(2)) && !divz_hit;
  assign pop_en    = divz_hit || ((state_r == S_CALC) && alu_rsp.done);
  assign pop_val   = divz_hit ? '0 : alu_result;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // Shared arithmetic unit; a is the second entry, b the top.
  assign alu_req.start = alu_start;
  assign alu_req.op    = tok_op_r;

  rpn_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .opa    (stack_r[1]),
    .opb    (stack_r[0]),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  // Control sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = alu_start ? S_CALC : S_OUT;
      end
      S_CALC: begin
        if (alu_rsp.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers: state, fill count, error latch, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      err_r       <= rpn_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (push_en) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop_en) begin
        cnt_r <= cnt_r - CW'(1);
      end else if (out_load && tok_last_r) begin
        cnt_r <= '0;
      end
      if (ovf_set) begin
        err_r <= rpn_pkg::ST_OVERFLOW;
      end else if (unf_set) begin
        err_r <= rpn_pkg::ST_UNDERFLOW;
      end else if (out_load && tok_last_r) begin
        err_r <= rpn_pkg::ST_OK;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Token capture and stack shifting; the top of stack lives in entry 0.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      tok_kind_r <= in_kind;
      tok_val_r  <= in_operand_value;
      tok_op_r   <= in_operation;
      tok_last_r <= in_last_token;
    end
    if (state_r == S_DECODE) begin
      divz_r <= divz_hit;
    end
    if (push_en) begin
      stack_r[0] <= {tok_val_r, 16'h0000};
      for (int i = 1; i < DEPTH; i++) begin
        stack_r[i] <= stack_r[i-1];
      end
    end else if (pop_en) begin
      stack_r[0] <= pop_val;
      for (int i = 1; i < DEPTH - 1; i++) begin
        stack_r[i] <= stack_r[i+1];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_done_r <= tok_last_r;
      if (!no_err) begin
        out_top_r    <= '0;
        out_status_r <= err_r;
      end else begin
        out_top_r    <= (cnt_r != '0) ? stack_r[0] : '0;
        out_status_r <= divz_r ? rpn_pkg::ST_DIVZERO : rpn_pkg::ST_OK;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_top_value       = out_top_r;
  assign out_status          = out_status_r;
  assign out_expression_done = out_done_r;

  // Conditions watched by the checks below.
  assign last_load = out_load && tok_last_r;
  assign err_shown = out_valid_r && ((out_status_r == rpn_pkg::ST_OVERFLOW) ||
                                     (out_status_r == rpn_pkg::ST_UNDERFLOW));

  `ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= CW'(DEPTH))
  `ASSERT_NXT(a_last_clears, clk, rst_n, last_load, (cnt_r == '0) && no_err)
  `ASSERT_IMP(a_err_top_zero, clk, rst_n, err_shown, out_top_r == '0)

endmodule
